/* hw/rtl/arpc_pkg.sv */
// ----------------------------------------------------------------------------
// arpc_pkg
// Types, codes and constants shared by the ARP neighbor cache modules.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int unsigned ENTRIES   = 64;
  localparam int unsigned IDX_W     = $clog2(ENTRIES);
  localparam int unsigned CNT_W     = $clog2(ENTRIES + 1);

  localparam int unsigned IP_W      = 32;
  localparam int unsigned MAC_W     = 48;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned STALE_W   = 16;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [IP_W-1:0]    IP_BCAST     = 32'hFFFF_FFFF;
  localparam logic [3:0]         MCAST_NIBBLE = 4'hE;
  localparam logic [23:0]        MCAST_OUI    = 24'h01_00_5E;
  localparam logic [MAC_W-1:0]   MAC_BCAST    = 48'hFFFF_FFFF_FFFF;
  localparam logic [STALE_W-1:0] STALE_RESET  = 16'd600;

  typedef enum logic [CMD_W-1:0] {
    CMD_RESOLVE = 2'd0,
    CMD_LEARN   = 2'd1,
    CMD_EXPIRE  = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_MISS   = 2'd1,
    STATUS_REJECT = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_IP      = 2'd0,
    CFG_STALE_AFTER = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] seen;
  } entry_t;

  // per-slot decision handed from the evaluator to the sequencer
  typedef struct packed {
    logic   hit;
    logic   wr_en;
    entry_t wr_data;
    logic   take_victim;
  } eval_t;

  // t is older than o when (o - t) mod 2^32 lies in 1 .. 2^31-1
  function automatic logic is_older(logic [TIME_W-1:0] t, logic [TIME_W-1:0] o);
    logic [TIME_W-1:0] d;
    d = o - t;
    return (d != '0) && !d[TIME_W-1];
  endfunction

endpackage

/* hw/rtl/arp_neighbor_cache.sv */
// ----------------------------------------------------------------------------
// arp_neighbor_cache
// IPv4-to-MAC neighbor cache with aging: resolve, learn and expire commands.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i/in_ready_o) carries command, address, MAC and
//   current time; one transaction on it yields exactly one transaction on the
//   result channel (out_valid_o/out_ready_i) with status and resolved MAC.
//   Config channel (cfg_valid_i/cfg_ready_o) writes own_ip (index 0) or
//   stale_after (index 1); it is always ready, write it only while idle.
//   Broadcast, multicast, address-zero resolves, rejected learns and unknown
//   commands skip the table walk and go straight to the result.
//   Resolve walks the table until the first hit; a miss walks all ENTRIES
//   slots. Expire always walks all ENTRIES slots; learn walks them all and
//   then writes the victim slot, but a learn that hits an existing address
//   stops at that slot.
//   The rate is set by the single read port of the slot memory: one slot
//   per cycle. One request is in flight at a time; the next is accepted once
//   the result sits in the output register, even if it is not yet taken.
//   A stalled receiver holds the result; a finished request waits for the
//   output register to free up.
//   Reset clears the per-slot valid bits at once (all slots read as zero)
//   and sets stale_after to 600.
// ----------------------------------------------------------------------------
module arp_neighbor_cache
  import arpc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [CMD_W-1:0]      command_i,
  input  logic [IP_W-1:0]       ip_address_i,
  input  logic [MAC_W-1:0]      mac_address_i,
  input  logic [TIME_W-1:0]     now_seconds_i,

  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [MAC_W-1:0]      resolved_mac_o,

  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_VICTIM = 4'b0100,
    ST_DONE   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [IP_W-1:0]    own_ip_q;
  logic [STALE_W-1:0] stale_after_q;

  // request registers
  logic [CMD_W-1:0]  cmd_q, cmd_d;
  logic [IP_W-1:0]   ip_q, ip_d;
  logic [MAC_W-1:0]  mac_q, mac_d;
  logic [TIME_W-1:0] now_q, now_d;

  // scan control
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              rd_pend_q, rd_pend_d;
  logic [IDX_W-1:0]  proc_idx_q, proc_idx_d;
  logic [TIME_W-1:0] oldest_q, oldest_d;
  logic [IDX_W-1:0]  victim_q, victim_d;
  logic              have_victim_q, have_victim_d;

  // pending result
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [MAC_W-1:0]    res_mac_q, res_mac_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [MAC_W-1:0]    rmac_q, rmac_d;

  // slot memory
  entry_t           slot_mem_q [ENTRIES];
  entry_t           rdata_q;
  logic [ENTRIES-1:0] valid_q;
  logic             rd_en;
  logic [IDX_W-1:0] raddr;
  logic             we;
  logic [IDX_W-1:0] waddr;
  entry_t           wdata;

  entry_t cur_entry;
  eval_t  eval;
  logic   in_fire;
  logic   learn_bad;

  assign in_ready_o     = (state_q == ST_IDLE);
  assign in_fire        = in_valid_i && in_ready_o;
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign resolved_mac_o = rmac_q;

  // a slot never written reads as all zero
  assign cur_entry = valid_q[proc_idx_q] ? rdata_q : '0;

  assign learn_bad = (ip_address_i == '0) || (ip_address_i == IP_BCAST) ||
                     (ip_address_i == own_ip_q) || (mac_address_i == '0);

  arpc_slot_eval u_slot_eval (
    .cmd_i         (cmd_q),
    .ip_i          (ip_q),
    .mac_i         (mac_q),
    .now_i         (now_q),
    .stale_after_i (stale_after_q),
    .oldest_i      (oldest_q),
    .entry_i       (cur_entry),
    .eval_o        (eval)
  );

  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    ip_d          = ip_q;
    mac_d         = mac_q;
    now_d         = now_q;
    cnt_d         = cnt_q;
    rd_pend_d     = rd_pend_q;
    proc_idx_d    = proc_idx_q;
    oldest_d      = oldest_q;
    victim_d      = victim_q;
    have_victim_d = have_victim_q;
    res_status_d  = res_status_q;
    res_mac_d     = res_mac_q;
    out_valid_d   = out_valid_q;
    status_d      = status_q;
    rmac_d        = rmac_q;
    rd_en         = 1'b0;
    raddr         = cnt_q[IDX_W-1:0];
    we            = 1'b0;
    waddr         = proc_idx_q;
    wdata         = eval.wr_data;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_d         = command_i;
          ip_d          = ip_address_i;
          mac_d         = mac_address_i;
          now_d         = now_seconds_i;
          cnt_d         = '0;
          rd_pend_d     = 1'b0;
          oldest_d      = now_seconds_i;
          have_victim_d = 1'b0;
          victim_d      = '0;
          res_status_d  = STATUS_OK;
          res_mac_d     = '0;
          state_d       = ST_DONE;
          unique case (command_i)
            CMD_RESOLVE: begin
              if (ip_address_i == IP_BCAST) begin
                res_mac_d = MAC_BCAST;
              end else if (ip_address_i[IP_W-1 -: 4] == MCAST_NIBBLE) begin
                res_mac_d = {MCAST_OUI, 1'b0, ip_address_i[22:0]};
              end else if (ip_address_i == '0) begin
                res_status_d = STATUS_MISS;
              end else begin
                state_d = ST_SCAN;
              end
            end
            CMD_LEARN: begin
              if (learn_bad) begin
                res_status_d = STATUS_REJECT;
              end else begin
                state_d = ST_SCAN;
              end
            end
            CMD_EXPIRE: begin
              state_d = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        // issue the next read while the previous slot is evaluated
        if (cnt_q < CNT_W'(ENTRIES)) begin
          rd_en      = 1'b1;
          raddr      = cnt_q[IDX_W-1:0];
          proc_idx_d = cnt_q[IDX_W-1:0];
          cnt_d      = cnt_q + CNT_W'(1);
          rd_pend_d  = 1'b1;
        end else begin
          rd_pend_d  = 1'b0;
        end

        if (rd_pend_q) begin
          we = eval.wr_en;
          if (eval.take_victim) begin
            oldest_d      = cur_entry.seen;
            victim_d      = proc_idx_q;
            have_victim_d = 1'b1;
          end
          if (eval.hit) begin
            res_status_d = STATUS_OK;
            res_mac_d    = (cmd_q == CMD_RESOLVE) ? cur_entry.mac : '0;
            rd_en        = 1'b0;
            state_d      = ST_DONE;
          end else if (proc_idx_q == IDX_W'(ENTRIES - 1)) begin
            res_mac_d = '0;
            if (cmd_q == CMD_RESOLVE) begin
              res_status_d = STATUS_MISS;
              state_d      = ST_DONE;
            end else if (cmd_q == CMD_LEARN) begin
              res_status_d = STATUS_OK;
              state_d      = ST_VICTIM;
            end else begin
              res_status_d = STATUS_OK;
              state_d      = ST_DONE;
            end
          end
        end
      end

      ST_VICTIM: begin
        we         = 1'b1;
        waddr      = have_victim_q ? victim_q : '0;
        wdata.ip   = ip_q;
        wdata.mac  = mac_q;
        wdata.seen = now_q;
        state_d    = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          rmac_d      = res_mac_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      slot_mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= slot_mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we) begin
      valid_q[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q      <= '0;
      stale_after_q <= STALE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_OWN_IP:      own_ip_q      <= cfg_data_i[IP_W-1:0];
        CFG_STALE_AFTER: stale_after_q <= cfg_data_i[STALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      rd_pend_q     <= 1'b0;
      cnt_q         <= '0;
      have_victim_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      rd_pend_q     <= rd_pend_d;
      cnt_q         <= cnt_d;
      have_victim_q <= have_victim_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    ip_q         <= ip_d;
    mac_q        <= mac_d;
    now_q        <= now_d;
    proc_idx_q   <= proc_idx_d;
    oldest_q     <= oldest_d;
    victim_q     <= victim_d;
    res_status_q <= res_status_d;
    res_mac_q    <= res_mac_d;
    status_q     <= status_d;
    rmac_q       <= rmac_d;
  end

endmodule

/* hw/rtl/arpc_slot_eval.sv */
// ----------------------------------------------------------------------------
// arpc_slot_eval
// Decides hit, write-back and victim choice for one table slot during a scan.
// ----------------------------------------------------------------------------
module arpc_slot_eval
  import arpc_pkg::*;
(
  input  logic [CMD_W-1:0]   cmd_i,
  input  logic [IP_W-1:0]    ip_i,
  input  logic [MAC_W-1:0]   mac_i,
  input  logic [TIME_W-1:0]  now_i,
  input  logic [STALE_W-1:0] stale_after_i,
  input  logic [TIME_W-1:0]  oldest_i,
  input  entry_t             entry_i,
  output eval_t              eval_o
);

  logic [IP_W-1:0]   ip_left;
  logic [TIME_W-1:0] age;

  always_comb begin
    eval_o         = '0;
    eval_o.wr_data = entry_i;
    ip_left        = entry_i.ip;
    age            = now_i - entry_i.seen;
    unique case (cmd_i)
      CMD_RESOLVE: begin
        eval_o.hit = (entry_i.ip == ip_i);
      end
      CMD_LEARN: begin
        if (entry_i.ip == ip_i) begin
          eval_o.hit          = 1'b1;
          eval_o.wr_en        = 1'b1;
          eval_o.wr_data.ip   = ip_i;
          eval_o.wr_data.mac  = mac_i;
          eval_o.wr_data.seen = now_i;
        end else begin
          // same MAC under another address: drop the stale mapping
          if (entry_i.mac == mac_i) begin
            ip_left           = '0;
            eval_o.wr_en      = 1'b1;
            eval_o.wr_data.ip = '0;
          end
          eval_o.take_victim = (ip_left == '0) || is_older(entry_i.seen, oldest_i);
        end
      end
      CMD_EXPIRE: begin
        if ((entry_i.ip != '0) && (age > {{(TIME_W-STALE_W){1'b0}}, stale_after_i})) begin
          eval_o.wr_en      = 1'b1;
          eval_o.wr_data.ip = '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* sim/arp_neighbor_cache_tb.sv */
// ----------------------------------------------------------------------------
// arp_neighbor_cache_tb
// Drives resolve, learn, expire and unknown-command requests into the neighbor cache and checks
// every result against a behavioral copy of the slot table, kept in step with
// each accepted request and register write. Random stalls on both channels,
// one long result back-pressure window and several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module arp_neighbor_cache_tb;
  import arpc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNDEF = 2'd3;

  localparam int unsigned POOL_SIZE     = 96;
  localparam int unsigned SETTLE_CYCLES = ENTRIES + 8;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned HOLD_AT       = 150;
  localparam int unsigned PHASE_ITEMS   = 95;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] now;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [MAC_W-1:0]    mac;
  } answer_t;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic [CMD_W-1:0]      command_i      = '0;
  logic [IP_W-1:0]       ip_address_i   = '0;
  logic [MAC_W-1:0]      mac_address_i  = '0;
  logic [TIME_W-1:0]     now_seconds_i  = '0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic [STATUS_W-1:0]   status_o;
  logic [MAC_W-1:0]      resolved_mac_o;
  logic                  cfg_valid_i    = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;

  arp_neighbor_cache dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .ip_address_i   (ip_address_i),
    .mac_address_i  (mac_address_i),
    .now_seconds_i  (now_seconds_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .resolved_mac_o (resolved_mac_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // shadow of the slot table and registers
  logic [IP_W-1:0]    nc_ip   [ENTRIES];
  logic [MAC_W-1:0]   nc_mac  [ENTRIES];
  logic [TIME_W-1:0]  nc_seen [ENTRIES];
  logic [IP_W-1:0]    own_ip_q;
  logic [STALE_W-1:0] stale_q;

  req_t    requests_q [$];
  answer_t answers_due [$];

  logic [IP_W-1:0]   ip_pool  [POOL_SIZE];
  logic [MAC_W-1:0]  mac_pool [POOL_SIZE];
  logic [TIME_W-1:0] now_s;

  int unsigned err_cnt        = 0;
  int unsigned answers_seen   = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned gap_left       = 0;
  int unsigned stall_left     = 0;
  int unsigned long_hold_left = 0;
  bit          long_hold_done = 1'b0;
  bit          calm           = 1'b0;
  logic        req_taken      = 1'b0;
  logic        cfg_taken      = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic answer_t neighbor_answer(req_t r);
    answer_t           ans;
    logic [TIME_W-1:0] oldest;
    logic [TIME_W-1:0] diff;
    int                victim;
    bit                hit;
    ans.status = STATUS_OK;
    ans.mac    = '0;
    case (r.cmd)
      CMD_RESOLVE: begin
        if (r.ip == IP_BCAST) begin
          ans.mac = MAC_BCAST;
        end else if (r.ip[IP_W-1 -: 4] == MCAST_NIBBLE) begin
          ans.mac = {MCAST_OUI, 1'b0, r.ip[22:0]};
        end else begin
          ans.status = STATUS_MISS;
          // walk downward so the lowest matching slot wins
          if (r.ip != '0) begin
            for (int i = ENTRIES - 1; i >= 0; i--) begin
              if (nc_ip[i] == r.ip) begin
                ans.status = STATUS_OK;
                ans.mac    = nc_mac[i];
              end
            end
          end
        end
      end
      CMD_LEARN: begin
        if (r.ip == '0 || r.ip == IP_BCAST || r.ip == own_ip_q || r.mac == '0) begin
          ans.status = STATUS_REJECT;
        end else begin
          victim = -1;
          oldest = r.now;
          hit    = 1'b0;
          for (int i = 0; i < ENTRIES && !hit; i++) begin
            if (nc_ip[i] == r.ip) begin
              nc_mac[i]  = r.mac;
              nc_seen[i] = r.now;
              hit        = 1'b1;
            end else begin
              if (nc_mac[i] == r.mac) nc_ip[i] = '0;
              diff = oldest - nc_seen[i];
              if (nc_ip[i] == '0 || (diff != '0 && !diff[TIME_W-1])) begin
                oldest = nc_seen[i];
                victim = i;
              end
            end
          end
          if (!hit) begin
            if (victim < 0) victim = 0;
            nc_ip[victim]   = r.ip;
            nc_mac[victim]  = r.mac;
            nc_seen[victim] = r.now;
          end
        end
      end
      CMD_EXPIRE: begin
        for (int i = 0; i < ENTRIES; i++) begin
          diff = r.now - nc_seen[i];
          if (nc_ip[i] != '0 && diff > TIME_W'(stale_q)) nc_ip[i] = '0;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  // result checking, shadow updates and watchdog
  always @(posedge clk_i) begin : monitor
    answer_t want;
    req_t    got_req;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        answers_seen++;
        if (answers_due.size() == 0) begin
          $error("result transaction with no request outstanding");
          err_cnt++;
        end else begin
          want = answers_due.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            err_cnt++;
          end
          if (resolved_mac_o !== want.mac) begin
            $error("resolved_mac: expected %h, got %h", want.mac, resolved_mac_o);
            err_cnt++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_OWN_IP:      own_ip_q = cfg_data_i[IP_W-1:0];
          CFG_STALE_AFTER: stale_q  = cfg_data_i[STALE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        got_req.cmd = command_i;
        got_req.ip  = ip_address_i;
        got_req.mac = mac_address_i;
        got_req.now = now_seconds_i;
        answers_due.push_back(neighbor_answer(got_req));
      end
      req_taken <= in_valid_i && in_ready_o;
      cfg_taken <= cfg_valid_i && cfg_ready_o;
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("arp_neighbor_cache: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // request driver
  always @(negedge clk_i) begin : driver
    req_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !req_taken) begin
      // hold until the transaction completes
    end else if (gap_left != 0) begin
      in_valid_i <= 1'b0;
      gap_left   <= gap_left - 1;
    end else if (requests_q.size() == 0) begin
      in_valid_i <= 1'b0;
    end else begin
      nxt = requests_q.pop_front();
      in_valid_i    <= 1'b1;
      command_i     <= nxt.cmd;
      ip_address_i  <= nxt.ip;
      mac_address_i <= nxt.mac;
      now_seconds_i <= nxt.now;
      if (!calm && $urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 7);
    end
  end

  // result receiver: short random stalls plus one long hold
  always @(negedge clk_i) begin : receiver
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (long_hold_left != 0) begin
      out_ready_i    <= 1'b0;
      long_hold_left <= long_hold_left - 1;
    end else if (!long_hold_done && answers_seen >= HOLD_AT) begin
      out_ready_i    <= 1'b0;
      long_hold_left <= LONG_HOLD - 1;
      long_hold_done <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 6);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    return MAC_W'({$urandom, $urandom});
  endfunction

  task automatic add_req(input logic [CMD_W-1:0] cmd, input logic [IP_W-1:0] ip,
                         input logic [MAC_W-1:0] mac, input logic [TIME_W-1:0] now);
    req_t r;
    r.cmd = cmd;
    r.ip  = ip;
    r.mac = mac;
    r.now = now;
    requests_q.push_back(r);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid_i <= 1'b0;
  endtask

  // wait until every request is answered, then let the block finish any
  // trailing slot write
  task automatic drain();
    while (requests_q.size() != 0 || in_valid_i || answers_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_random(input int unsigned count);
    int unsigned      roll;
    int unsigned      sub;
    int unsigned      pick;
    logic [MAC_W-1:0] mac;
    for (int n = 0; n < count; n++) begin
      now_s = now_s + $urandom_range(0, 6);
      if ($urandom_range(0, 49) == 0) now_s = $urandom;
      else if ($urandom_range(0, 49) == 0) now_s = now_s - $urandom_range(1, 40);
      roll = $urandom_range(0, 99);
      sub  = $urandom_range(0, 19);
      pick = $urandom_range(0, POOL_SIZE - 1);
      if (roll < 42) begin
        case (sub)
          0:       add_req(CMD_RESOLVE, IP_BCAST, rand_mac(), now_s);
          1:       add_req(CMD_RESOLVE, {MCAST_NIBBLE, 28'($urandom)}, rand_mac(), now_s);
          2:       add_req(CMD_RESOLVE, '0, rand_mac(), now_s);
          3:       add_req(CMD_RESOLVE, $urandom, rand_mac(), now_s);
          default: add_req(CMD_RESOLVE, ip_pool[pick], rand_mac(), now_s);
        endcase
      end else if (roll < 82) begin
        // mostly stable pairs; now and then a MAC moves to another address
        mac = ($urandom_range(0, 7) == 0) ? mac_pool[$urandom_range(0, POOL_SIZE - 1)]
                                          : mac_pool[pick];
        case (sub)
          0:       add_req(CMD_LEARN, '0, mac, now_s);
          1:       add_req(CMD_LEARN, IP_BCAST, mac, now_s);
          2:       add_req(CMD_LEARN, own_ip_q, mac, now_s);
          3:       add_req(CMD_LEARN, ip_pool[pick], '0, now_s);
          default: add_req(CMD_LEARN, ip_pool[pick], mac, now_s);
        endcase
      end else if (roll < 94) begin
        add_req(CMD_EXPIRE, $urandom, rand_mac(), now_s);
      end else begin
        add_req(CMD_UNDEF, $urandom, rand_mac(), $urandom);
      end
    end
  endtask

  initial begin : stimulus
    logic [TIME_W-1:0] t0;
    own_ip_q = '0;
    stale_q  = STALE_RESET;
    for (int i = 0; i < ENTRIES; i++) begin
      nc_ip[i]   = '0;
      nc_mac[i]  = '0;
      nc_seen[i] = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) begin
      do ip_pool[i] = $urandom; while (ip_pool[i] == '0 || ip_pool[i] == IP_BCAST);
      do mac_pool[i] = rand_mac(); while (mac_pool[i] == '0);
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_reg(CFG_OWN_IP, ip_pool[POOL_SIZE - 1]);
    write_reg(CFG_STALE_AFTER, CFG_DATA_W'(20));
    @(posedge clk_i);

    t0 = 32'h0000_1000;
    add_req(CMD_RESOLVE, IP_BCAST, rand_mac(), t0);
    add_req(CMD_RESOLVE, 32'hE000_0000, rand_mac(), t0);
    add_req(CMD_RESOLVE, 32'hEFFF_FFFF, rand_mac(), t0);
    add_req(CMD_RESOLVE, '0, rand_mac(), t0);
    add_req(CMD_RESOLVE, ip_pool[0], rand_mac(), t0);
    // every reject reason
    add_req(CMD_LEARN, '0, mac_pool[0], t0);
    add_req(CMD_LEARN, IP_BCAST, mac_pool[0], t0);
    add_req(CMD_LEARN, ip_pool[POOL_SIZE - 1], mac_pool[0], t0);
    add_req(CMD_LEARN, ip_pool[0], '0, t0);
    add_req(CMD_LEARN, ip_pool[0], mac_pool[0], t0);
    add_req(CMD_RESOLVE, ip_pool[0], rand_mac(), t0);
    add_req(CMD_LEARN, ip_pool[0], mac_pool[1], t0 + 1);
    // same MAC under a new address knocks out the old slot
    add_req(CMD_LEARN, ip_pool[1], mac_pool[1], t0 + 2);
    add_req(CMD_RESOLVE, ip_pool[0], rand_mac(), t0 + 2);
    add_req(CMD_LEARN, 32'hFFFF_FFFE, MAC_BCAST, t0 + 3);
    add_req(CMD_LEARN, 32'h0000_0001, 48'h1, t0 + 4);
    add_req(CMD_LEARN, 32'hE000_0001, mac_pool[2], t0 + 5);
    add_req(CMD_RESOLVE, 32'hE000_0001, rand_mac(), t0 + 5);
    add_req(CMD_RESOLVE, 32'hFFFF_FFFE, rand_mac(), t0 + 5);
    // stamps on both sides of the wrap
    add_req(CMD_LEARN, ip_pool[2], mac_pool[3], 32'hFFFF_FFFF);
    add_req(CMD_LEARN, ip_pool[3], mac_pool[4], '0);
    add_req(CMD_EXPIRE, '0, rand_mac(), t0 + 10);
    add_req(CMD_EXPIRE, '0, rand_mac(), t0 + 100);
    add_req(CMD_RESOLVE, 32'h0000_0001, rand_mac(), t0 + 100);
    add_req(CMD_UNDEF, $urandom, rand_mac(), $urandom);
    now_s = t0 + 100;

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(CFG_OWN_IP, ip_pool[3]);
          write_reg(CFG_STALE_AFTER, {16'($urandom), 16'd30});
        end
        1: begin
          write_reg(CFG_OWN_IP, IP_BCAST);
          write_reg(CFG_STALE_AFTER, CFG_DATA_W'(0));
        end
        2: begin
          write_reg(CFG_OWN_IP, '0);
          write_reg(CFG_STALE_AFTER, CFG_DATA_W'(16'hFFFF));
        end
        3: begin
          write_reg(CFG_OWN_IP, ip_pool[7]);
          write_reg(CFG_STALE_AFTER, CFG_DATA_W'($urandom_range(5, 60)));
        end
        default: begin
          write_reg(CFG_OWN_IP, $urandom);
          write_reg(CFG_STALE_AFTER, CFG_DATA_W'(STALE_RESET));
          calm = 1'b1;
        end
      endcase
      @(posedge clk_i);
      queue_random(PHASE_ITEMS);
    end

    drain();
    if (err_cnt == 0) $display("arp_neighbor_cache: match");
    else $display("arp_neighbor_cache: mismatch");
    $finish;
  end

endmodule
